/* hdl/pfb_pkg.sv */
// Shared types, constants and helpers of the page framebuffer fill engine.
package pfb_pkg;

  localparam int unsigned DefScreenWidth = 128;
  localparam int unsigned DefScreenPages = 8;
  // Address width that covers the largest legal store (256 x 16 bytes).
  localparam int unsigned AddrWMax = 12;

  typedef enum logic [1:0] {
    REQ_RECT  = 2'd0,
    REQ_DISC  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef struct packed {
    logic                rd_en;
    logic [AddrWMax-1:0] rd_addr;
    logic                wr_en;
    logic [AddrWMax-1:0] wr_addr;
    logic [7:0]          wr_data;
  } mem_req_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
  } done_t;

  // Bits of one page byte whose row lies within [lo, hi].
  function automatic logic [7:0] page_mask(input logic [4:0] page, input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic [7:0] m;
    logic [7:0] y;
    for (int b = 0; b < 8; b++) begin
      y    = {page[4:0], 3'(b)};
      m[b] = (y >= lo) && (y <= hi);
    end
    return m;
  endfunction

endpackage

/* hdl/pfb_if.sv */
// Request and response channel interfaces of the page framebuffer fill engine.
interface pfb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] corner_x_a;
  logic [5:0] corner_y_a;
  logic [6:0] corner_x_b;
  logic [5:0] corner_y_b;
  logic [6:0] center_x;
  logic [5:0] center_y;
  logic [6:0] radius;
  logic [9:0] byte_index;

  modport source(output valid, req_type, corner_x_a, corner_y_a, corner_x_b, corner_y_b,
                 center_x, center_y, radius, byte_index, input ready);
  modport sink(input valid, req_type, corner_x_a, corner_y_a, corner_x_b, corner_y_b,
               center_x, center_y, radius, byte_index, output ready);
endinterface

interface pfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [1:0] done_kind;

  modport source(output valid, read_byte, done_kind, input ready);
  modport sink(input valid, read_byte, done_kind, output ready);
endinterface

/* hdl/page_framebuffer_shape_fill.sv */
// Top level of the page framebuffer fill engine: sequencer, byte store and response register.
//
//   Channel  Modport  Carries
//   req_i    sink     req_type, corners, disc center and radius, byte_index
//   rsp_o    source   read_byte, done_kind
//
// A request is taken only while idle. Fills run a setup step per column and then one
// read-modify-write step per touched page byte; a disc also steps its height down and
// its column offset out between columns. A clear sweeps every byte of the store to
// zero and a read fetches one byte. After reset the store is swept to zero before the
// first request is taken. A stalled response holds the sequencer at its last step.
module page_framebuffer_shape_fill import pfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = DefScreenWidth,
  parameter int unsigned SCREEN_PAGES = DefScreenPages
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfb_req_if.sink   req_i,
  pfb_rsp_if.source rsp_o
);

  mem_req_t   mem_req;
  done_t      done;
  logic [7:0] rd_data;
  logic       out_free;
  logic       rsp_valid_q;
  logic [7:0] rsp_data_q;
  logic [1:0] rsp_kind_q;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  pfb_seq #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_PAGES(SCREEN_PAGES)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .out_free_i(out_free),
    .rd_data_i (rd_data),
    .mem_req_o (mem_req),
    .done_o    (done)
  );

  pfb_store #(
    .DEPTH(SCREEN_WIDTH * SCREEN_PAGES)
  ) u_store (
    .clk_i    (clk_i),
    .mem_req_i(mem_req),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (done.valid) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid) begin
      rsp_data_q <= done.data;
      rsp_kind_q <= done.kind;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_byte = rsp_data_q;
  assign rsp_o.done_kind = rsp_kind_q;

`ifndef SYNTH
  // A finished request never overwrites a response that is still waiting.
  a_no_rsp_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |-> (!rsp_valid_q || rsp_o.ready))
    else $error("response register overwritten");

  // Read and write of the same cycle never touch the same byte.
  a_no_rmw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
    else $error("read and write collide on one byte");

  // All writes of a fill have drained before the next request is taken.
  a_drained_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !mem_req.wr_en)
    else $error("request taken with a write still pending");
`endif

endmodule

/* hdl/pfb_store.sv */
// Framebuffer byte store: one write port and one registered read port.
module pfb_store import pfb_pkg::*; #(
  parameter int unsigned DEPTH = DefScreenWidth * DefScreenPages,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic       clk_i,
  input  mem_req_t   mem_req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr[AW-1:0]] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem_q[mem_req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/pfb_seq.sv */
// Drawing sequencer: column walker, disc height stepper and read-modify-write control.
module pfb_seq import pfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = DefScreenWidth,
  parameter int unsigned SCREEN_PAGES = DefScreenPages,
  localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_PAGES,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfb_req_if.sink    req_i,
  input  logic       out_free_i,
  input  logic [7:0] rd_data_i,
  output mem_req_t   mem_req_o,
  output done_t      done_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DSTEP, S_COLSET, S_COL, S_RDCAP, S_FIN
  } state_e;

  localparam logic signed [9:0] XLim = 10'(SCREEN_WIDTH);
  localparam logic signed [8:0] YMax = 9'(SCREEN_PAGES * 8 - 1);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  // Control state.
  state_e        state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_emit_q, clr_emit_d;
  logic          wr_pend_q, wr_pend_d;

  // Working registers.
  logic [1:0]          kind_q, kind_d;
  logic [7:0]          data_q, data_d;
  logic signed [9:0]   col_x_q, col_x_d;
  logic signed [8:0]   ylo_q, ylo_d, yhi_q, yhi_d;
  logic [6:0]          x_end_q, x_end_d;
  logic [6:0]          cx_q, cx_d;
  logic [5:0]          cy_q, cy_d;
  logic [15:0]         r2_q, r2_d;
  logic [6:0]          h_q, h_d;
  logic [7:0]          k_q, k_d;
  logic [15:0]         hh_q, hh_d, kk_q, kk_d;
  logic                side_q, side_d;
  logic [4:0]          pg_q, pg_d, pg_end_q, pg_end_d;
  logic [7:0]          clo_q, clo_d, chi_q, chi_d;
  logic [AddrWMax-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]          wr_mask_q, wr_mask_d;

  logic                col_done;
  logic [16:0]         dist_sum;
  logic [AddrWMax-1:0] col_addr;
  logic [7:0]          lo_clip, hi_clip;
  logic [6:0]          x_lo, x_hi;
  logic [5:0]          y_lo, y_hi;

  assign req_i.ready = (state_q == S_IDLE);

  // The distance adder: squared height plus squared column offset against r squared.
  assign dist_sum = {1'b0, hh_q} + {1'b0, kk_q};
  assign col_addr = {3'b0, col_x_q[8:0]} + AddrWMax'(pg_q) * AddrWMax'(SCREEN_WIDTH);
  assign lo_clip  = (ylo_q < 0) ? 8'd0 : ylo_q[7:0];
  assign hi_clip  = (yhi_q > YMax) ? YMax[7:0] : yhi_q[7:0];
  assign x_lo     = (req_i.corner_x_a < req_i.corner_x_b) ? req_i.corner_x_a : req_i.corner_x_b;
  assign x_hi     = (req_i.corner_x_a < req_i.corner_x_b) ? req_i.corner_x_b : req_i.corner_x_a;
  assign y_lo     = (req_i.corner_y_a < req_i.corner_y_b) ? req_i.corner_y_a : req_i.corner_y_b;
  assign y_hi     = (req_i.corner_y_a < req_i.corner_y_b) ? req_i.corner_y_b : req_i.corner_y_a;

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    clr_emit_d = clr_emit_q;
    wr_pend_d  = 1'b0;
    kind_d     = kind_q;
    data_d     = data_q;
    col_x_d    = col_x_q;
    ylo_d      = ylo_q;
    yhi_d      = yhi_q;
    x_end_d    = x_end_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    r2_d       = r2_q;
    h_d        = h_q;
    k_d        = k_q;
    hh_d       = hh_q;
    kk_d       = kk_q;
    side_d     = side_q;
    pg_d       = pg_q;
    pg_end_d   = pg_end_q;
    clo_d      = clo_q;
    chi_d      = chi_q;
    wr_addr_d  = wr_addr_q;
    wr_mask_d  = wr_mask_q;
    col_done   = 1'b0;
    done_o     = '0;

    // The write half of a read-modify-write lands in the cycle after its read.
    mem_req_o         = '0;
    mem_req_o.wr_en   = wr_pend_q;
    mem_req_o.wr_addr = wr_addr_q;
    mem_req_o.wr_data = rd_data_i | wr_mask_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = AddrWMax'(clr_cnt_q);
        mem_req_o.wr_data = 8'd0;
        if (clr_cnt_q == LastAddr) begin
          state_d = clr_emit_q ? S_FIN : S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d = req_i.req_type;
          data_d = 8'd0;
          unique case (req_e'(req_i.req_type))
            REQ_RECT: begin
              col_x_d = $signed({3'b0, x_lo});
              x_end_d = x_hi;
              ylo_d   = $signed({3'b0, y_lo});
              yhi_d   = $signed({3'b0, y_hi});
              state_d = S_COLSET;
            end
            REQ_DISC: begin
              cx_d    = req_i.center_x;
              cy_d    = req_i.center_y;
              r2_d    = {2'b0, {7'b0, req_i.radius} * {7'b0, req_i.radius}};
              h_d     = req_i.radius;
              hh_d    = {2'b0, {7'b0, req_i.radius} * {7'b0, req_i.radius}};
              k_d     = 8'd0;
              kk_d    = 16'd0;
              side_d  = 1'b0;
              state_d = S_DSTEP;
            end
            REQ_CLEAR: begin
              clr_cnt_d  = '0;
              clr_emit_d = 1'b1;
              state_d    = S_CLEAR;
            end
            REQ_READ: begin
              if ({3'b0, req_i.byte_index} < 13'(DEPTH)) begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = {2'b0, req_i.byte_index};
                state_d           = S_RDCAP;
              end else begin
                state_d = S_FIN;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_DSTEP: begin
        if (kk_q > r2_q) begin
          // Column offset has passed the radius.
          state_d = S_FIN;
        end else if (dist_sum > {1'b0, r2_q}) begin
          h_d  = h_q - 7'd1;
          hh_d = hh_q - {8'b0, h_q, 1'b0} + 16'd1;
        end else begin
          col_x_d = $signed({3'b0, cx_q}) + $signed({2'b0, k_q});
          ylo_d   = $signed({3'b0, cy_q}) - $signed({2'b0, h_q});
          yhi_d   = $signed({3'b0, cy_q}) + $signed({2'b0, h_q});
          state_d = S_COLSET;
        end
      end
      S_COLSET: begin
        if (col_x_q >= 0 && col_x_q < XLim && yhi_q >= 0 && ylo_q <= YMax) begin
          clo_d    = lo_clip;
          chi_d    = hi_clip;
          pg_d     = lo_clip[7:3];
          pg_end_d = hi_clip[7:3];
          state_d  = S_COL;
        end else begin
          col_done = 1'b1;
        end
      end
      S_COL: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = col_addr;
        wr_pend_d         = 1'b1;
        wr_addr_d         = col_addr;
        wr_mask_d         = page_mask(pg_q, clo_q, chi_q);
        if (pg_q == pg_end_q) begin
          col_done = 1'b1;
        end else begin
          pg_d = pg_q + 5'd1;
        end
      end
      S_RDCAP: begin
        data_d  = rd_data_i;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free_i) begin
          done_o.valid = 1'b1;
          done_o.kind  = kind_q;
          done_o.data  = data_q;
          clr_emit_d   = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Advance to the next column of the shape.
    if (col_done) begin
      if (kind_q == REQ_RECT) begin
        if (col_x_q == $signed({3'b0, x_end_q})) begin
          state_d = S_FIN;
        end else begin
          col_x_d = col_x_q + 10'sd1;
          state_d = S_COLSET;
        end
      end else if (!side_q && k_q != 8'd0) begin
        side_d  = 1'b1;
        col_x_d = $signed({3'b0, cx_q}) - $signed({2'b0, k_q});
        state_d = S_COLSET;
      end else begin
        side_d  = 1'b0;
        k_d     = k_q + 8'd1;
        kk_d    = kk_q + {7'b0, k_q, 1'b0} + 16'd1;
        state_d = S_DSTEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      clr_emit_q <= 1'b0;
      wr_pend_q  <= 1'b0;
      kind_q     <= REQ_RECT;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_emit_q <= clr_emit_d;
      wr_pend_q  <= wr_pend_d;
      kind_q     <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    col_x_q   <= col_x_d;
    ylo_q     <= ylo_d;
    yhi_q     <= yhi_d;
    x_end_q   <= x_end_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    r2_q      <= r2_d;
    h_q       <= h_d;
    k_q       <= k_d;
    hh_q      <= hh_d;
    kk_q      <= kk_d;
    side_q    <= side_d;
    pg_q      <= pg_d;
    pg_end_q  <= pg_end_d;
    clo_q     <= clo_d;
    chi_q     <= chi_d;
    wr_addr_q <= wr_addr_d;
    wr_mask_q <= wr_mask_d;
  end

endmodule

/* test/tb_page_framebuffer_shape_fill.sv */
// Self-checking testbench of the page framebuffer fill engine with a shadow pixel store.
`timescale 1ns / 1ps

module tb_page_framebuffer_shape_fill;
  import pfb_pkg::*;

  localparam int ScreenW    = DefScreenWidth;
  localparam int ScreenRows = DefScreenPages * 8;
  localparam int StoreBytes = DefScreenWidth * DefScreenPages;

  typedef struct packed {
    req_e       kind;
    logic [6:0] xa;
    logic [5:0] ya;
    logic [6:0] xb;
    logic [5:0] yb;
    logic [6:0] cx;
    logic [5:0] cy;
    logic [6:0] rad;
    logic [9:0] idx;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } draw_rsp_t;

  logic clk_i;
  logic rst_ni;

  pfb_req_if req_bus ();
  pfb_rsp_if rsp_bus ();

  page_framebuffer_shape_fill i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  logic [7:0] fb_shadow [StoreBytes];
  draw_rsp_t  expected_rsp_q [$];
  int         error_count   = 0;
  int         send_idle_pct = 0;
  int         rsp_stall_pct = 0;
  // Last drawn spot, so that reads often land on pixels that were just set.
  int         hot_x = 0;
  int         hot_y = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    draw_rsp_t want;
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected response: done_kind %0d read_byte 0x%02h",
               rsp_bus.done_kind, rsp_bus.read_byte);
        error_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_bus.done_kind !== want.kind) begin
          $error("done_kind: expected %0d, got %0d", want.kind, rsp_bus.done_kind);
          error_count++;
        end
        if (rsp_bus.read_byte !== want.data) begin
          $error("read_byte: expected 0x%02h, got 0x%02h", want.data, rsp_bus.read_byte);
          error_count++;
        end
      end
    end
  end

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void shadow_set(int x, int y);
    if (x < 0 || x >= ScreenW || y < 0 || y >= ScreenRows) return;
    fb_shadow[x + (y / 8) * ScreenW] = fb_shadow[x + (y / 8) * ScreenW] | (8'd1 << (y % 8));
  endfunction

  // Applies one request to the shadow store and returns the response it must produce.
  function automatic draw_rsp_t shadow_apply(draw_req_t r);
    draw_rsp_t rsp;
    int x0, x1, y0, y1, rr;
    rsp.data = 8'h00;
    rsp.kind = r.kind;
    case (r.kind)
      REQ_RECT: begin
        x0 = (r.xa < r.xb) ? int'(r.xa) : int'(r.xb);
        x1 = (r.xa < r.xb) ? int'(r.xb) : int'(r.xa);
        y0 = (r.ya < r.yb) ? int'(r.ya) : int'(r.yb);
        y1 = (r.ya < r.yb) ? int'(r.yb) : int'(r.ya);
        for (int x = x0; x <= x1; x++)
          for (int y = y0; y <= y1; y++) shadow_set(x, y);
      end
      REQ_DISC: begin
        rr = int'(r.rad);
        for (int dx = -rr; dx <= rr; dx++)
          for (int dy = -rr; dy <= rr; dy++)
            if (dx * dx + dy * dy <= rr * rr) shadow_set(int'(r.cx) + dx, int'(r.cy) + dy);
      end
      REQ_CLEAR: begin
        foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
      end
      default: begin
        if (int'(r.idx) < StoreBytes) rsp.data = fb_shadow[r.idx];
      end
    endcase
    return rsp;
  endfunction

  // Fields that a request does not use still carry random values.
  function automatic draw_req_t rand_fields(req_e kind);
    draw_req_t r;
    r.kind = kind;
    r.xa   = 7'($urandom_range(127));
    r.ya   = 6'($urandom_range(63));
    r.xb   = 7'($urandom_range(127));
    r.yb   = 6'($urandom_range(63));
    r.cx   = 7'($urandom_range(127));
    r.cy   = 6'($urandom_range(63));
    r.rad  = 7'($urandom_range(127));
    r.idx  = 10'($urandom_range(1023));
    return r;
  endfunction

  function automatic draw_req_t rect_req(int xa, int ya, int xb, int yb);
    draw_req_t r;
    r    = rand_fields(REQ_RECT);
    r.xa = 7'(xa);
    r.ya = 6'(ya);
    r.xb = 7'(xb);
    r.yb = 6'(yb);
    return r;
  endfunction

  function automatic draw_req_t disc_req(int cx, int cy, int rad);
    draw_req_t r;
    r     = rand_fields(REQ_DISC);
    r.cx  = 7'(cx);
    r.cy  = 6'(cy);
    r.rad = 7'(rad);
    return r;
  endfunction

  function automatic draw_req_t read_req(int idx);
    draw_req_t r;
    r     = rand_fields(REQ_READ);
    r.idx = 10'(idx);
    return r;
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t r;
    int pick;
    int x, y;
    pick = $urandom_range(99);
    if (pick < 40) begin
      r = rand_fields(REQ_READ);
      if ($urandom_range(1) == 1) begin
        x     = clampi(hot_x + int'($urandom_range(16)) - 8, 0, ScreenW - 1);
        y     = clampi(hot_y + int'($urandom_range(16)) - 8, 0, ScreenRows - 1);
        r.idx = 10'(x + (y / 8) * ScreenW);
      end
    end else if (pick < 70) begin
      r = rand_fields(REQ_RECT);
      // Most rectangles are small; a few span whatever the corners give.
      if ($urandom_range(9) != 0) begin
        r.xb = 7'(clampi(int'(r.xa) + int'($urandom_range(24)) - 12, 0, 127));
        r.yb = 6'(clampi(int'(r.ya) + int'($urandom_range(24)) - 12, 0, 63));
      end
      hot_x = int'(r.xa);
      hot_y = int'(r.ya);
    end else if (pick < 95) begin
      r = rand_fields(REQ_DISC);
      if ($urandom_range(99) < 85) r.rad = 7'($urandom_range(10));
      hot_x = int'(r.cx);
      hot_y = int'(r.cy);
    end else begin
      r = rand_fields(REQ_CLEAR);
    end
    return r;
  endfunction

  // Presents one request and records its expected response once it is taken.
  // Valid is left high after acceptance so back-to-back requests need no bubble.
  task automatic send_request(input draw_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= r.kind;
    req_bus.corner_x_a <= r.xa;
    req_bus.corner_y_a <= r.ya;
    req_bus.corner_x_b <= r.xb;
    req_bus.corner_y_b <= r.yb;
    req_bus.center_x   <= r.cx;
    req_bus.center_y   <= r.cy;
    req_bus.radius     <= r.rad;
    req_bus.byte_index <= r.idx;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    expected_rsp_q.push_back(shadow_apply(r));
  endtask

  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_after_reset();
    send_request(read_req(0));
    send_request(read_req(StoreBytes - 1));
    drain_responses();
  endtask

  task automatic test_rect_corners();
    send_request(rect_req(0, 0, 127, 63));
    send_request(read_req(512));
    send_request(rand_fields(REQ_CLEAR));
    send_request(read_req(512));
    // Corners given high-to-low must cover the same area as low-to-high.
    send_request(rect_req(127, 63, 120, 57));
    send_request(read_req(127 + 7 * ScreenW));
    send_request(rect_req(5, 9, 5, 9));
    send_request(read_req(5 + ScreenW));
    drain_responses();
  endtask

  task automatic test_disc_edges();
    send_request(disc_req(64, 32, 0));
    send_request(read_req(64 + 4 * ScreenW));
    send_request(disc_req(0, 0, 6));
    send_request(read_req(0));
    // Largest radius from the far corner: most of the disc lies off the screen.
    send_request(disc_req(127, 63, 127));
    send_request(read_req(0));
    send_request(disc_req(100, 20, 9));
    send_request(read_req(100 + 2 * ScreenW));
    drain_responses();
  endtask

  task automatic test_clear_store();
    send_request(rand_fields(REQ_CLEAR));
    send_request(read_req(StoreBytes - 1));
    send_request(read_req(0));
    drain_responses();
  endtask

  task automatic test_random_mix(input int sender_idle, input int receiver_stall,
                                 input int count);
    send_idle_pct = sender_idle;
    rsp_stall_pct = receiver_stall;
    repeat (count) send_request(random_request());
    drain_responses();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= REQ_RECT;
    req_bus.corner_x_a <= '0;
    req_bus.corner_y_a <= '0;
    req_bus.corner_x_b <= '0;
    req_bus.corner_y_b <= '0;
    req_bus.center_x   <= '0;
    req_bus.center_y   <= '0;
    req_bus.radius     <= '0;
    req_bus.byte_index <= '0;
    foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 13;
    rsp_stall_pct = 53;
    test_after_reset();
    test_rect_corners();
    test_disc_edges();
    test_clear_store();

    test_random_mix(13, 53, 187);
    test_random_mix(53, 13, 187);
    test_random_mix(0, 0, 186);

    repeat (16) @(posedge clk_i);
    if (error_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
